### rtl/pchsn_pkg.sv
// pchsn_pkg: shared types, constants and helpers for the half-shell neighbor generator.
// No dependencies.
package pchsn_pkg;

  localparam int unsigned SIZE_W    = 7;
  localparam int unsigned COORD_W   = 6;
  localparam int unsigned AREA_W    = 13;
  localparam int unsigned NB_W      = 18;
  localparam int unsigned IDX_W     = 12;
  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned CNT_W     = 6;
  localparam int unsigned ADDR_W    = 18;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QPTR_W    = 2;

  localparam logic [SLOT_W-1:0]  LAST_SLOT = 4'd12;
  localparam logic [CNT_W-1:0]   CNT_MAX   = 6'd63;
  localparam logic [SIZE_W-1:0]  SIZE_MAX  = 7'd64;

  localparam logic [SIZE_W-1:0]  SIZE_X_RST = 7'd16;
  localparam logic [SIZE_W-1:0]  SIZE_Y_RST = 7'd16;
  localparam logic [SIZE_W-1:0]  SIZE_Z_RST = 7'd16;
  localparam logic [SIZE_W-1:0]  STRIDE_RST = 7'd13;

  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIST_STRIDE = 2'd3;

  localparam logic [1:0] OFF_ZERO  = 2'd0;
  localparam logic [1:0] OFF_PLUS  = 2'd1;
  localparam logic [1:0] OFF_MINUS = 2'd2;

  typedef struct packed {
    logic [SIZE_W-1:0] size_x;
    logic [SIZE_W-1:0] size_y;
    logic [SIZE_W-1:0] size_z;
    logic [SIZE_W-1:0] list_stride;
  } cfg_t;

  typedef struct packed {
    logic [1:0] dx;
    logic [1:0] dy;
    logic [1:0] dz;
  } offset_t;

  typedef struct packed {
    logic [NB_W-1:0]   nb;
    logic [NB_W-1:0]   cell_idx;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } nbr_req_t;

  typedef struct packed {
    logic clearing;
  } back_stat_t;

  function automatic offset_t slot_offset(logic [SLOT_W-1:0] s);
    offset_t o;
    unique case (s)
      4'd0:    o = '{OFF_PLUS,  OFF_ZERO,  OFF_ZERO};
      4'd1:    o = '{OFF_PLUS,  OFF_PLUS,  OFF_ZERO};
      4'd2:    o = '{OFF_PLUS,  OFF_PLUS,  OFF_PLUS};
      4'd3:    o = '{OFF_PLUS,  OFF_ZERO,  OFF_PLUS};
      4'd4:    o = '{OFF_ZERO,  OFF_PLUS,  OFF_ZERO};
      4'd5:    o = '{OFF_MINUS, OFF_PLUS,  OFF_ZERO};
      4'd6:    o = '{OFF_MINUS, OFF_PLUS,  OFF_PLUS};
      4'd7:    o = '{OFF_ZERO,  OFF_PLUS,  OFF_PLUS};
      4'd8:    o = '{OFF_ZERO,  OFF_ZERO,  OFF_PLUS};
      4'd9:    o = '{OFF_MINUS, OFF_ZERO,  OFF_PLUS};
      4'd10:   o = '{OFF_MINUS, OFF_MINUS, OFF_PLUS};
      4'd11:   o = '{OFF_ZERO,  OFF_MINUS, OFF_PLUS};
      4'd12:   o = '{OFF_PLUS,  OFF_MINUS, OFF_PLUS};
      default: o = '{OFF_ZERO,  OFF_ZERO,  OFF_ZERO};
    endcase
    return o;
  endfunction

  function automatic logic [COORD_W-1:0] wrap_step(logic [COORD_W-1:0] c, logic [1:0] d,
                                                   logic [SIZE_W-1:0] n);
    logic [SIZE_W-1:0] inc;
    logic [COORD_W-1:0] r;
    inc = {1'b0, c} + 7'd1;
    case (d)
      OFF_PLUS:  r = (inc >= n) ? '0 : inc[COORD_W-1:0];
      OFF_MINUS: r = (c == '0) ? COORD_W'(n - 7'd1) : c - 6'd1;
      default:   r = c;
    endcase
    return r;
  endfunction

  function automatic logic [SIZE_W-1:0] eff_size(logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    if (s == '0) r = 7'd1;
    else if (s > SIZE_MAX) r = SIZE_MAX;
    else r = s;
    return r;
  endfunction

  function automatic logic [COORD_W-1:0] clamp_coord(logic [COORD_W-1:0] c,
                                                     logic [SIZE_W-1:0] n);
    return ({1'b0, c} >= n) ? COORD_W'(n - 7'd1) : c;
  endfunction

endpackage

### rtl/pchsn_front.sv
// pchsn_front: accepts a cell, clamps it and steps through its 13 half-shell neighbors.
// Depends on pchsn_pkg; feeds pchsn_queue.
module pchsn_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pchsn_pkg::cfg_t               cfg,
  input  logic                          accept,
  input  logic [pchsn_pkg::COORD_W-1:0] cell_x,
  input  logic [pchsn_pkg::COORD_W-1:0] cell_y,
  input  logic [pchsn_pkg::COORD_W-1:0] cell_z,
  output logic                          busy,
  output logic                          push,
  input  logic                          push_ready,
  output pchsn_pkg::nbr_req_t           push_data
);

  typedef enum logic {F_IDLE, F_GEN} fstate_t;

  fstate_t                          state_r;
  logic [pchsn_pkg::SLOT_W-1:0]     slot_r;
  logic [pchsn_pkg::COORD_W-1:0]    x_r, y_r, z_r;
  logic [pchsn_pkg::SIZE_W-1:0]     nx_r, ny_r, nz_r;
  logic [pchsn_pkg::AREA_W-1:0]     nxny_r;

  logic [pchsn_pkg::SIZE_W-1:0]     nx_nxt, ny_nxt, nz_nxt;
  pchsn_pkg::offset_t               off;
  logic [pchsn_pkg::COORD_W-1:0]    bx, by, bz;
  logic                             last_push;

  always_comb begin
    nx_nxt = pchsn_pkg::eff_size(cfg.size_x);
    ny_nxt = pchsn_pkg::eff_size(cfg.size_y);
    nz_nxt = pchsn_pkg::eff_size(cfg.size_z);
    off    = pchsn_pkg::slot_offset(slot_r);
    bx     = pchsn_pkg::wrap_step(x_r, off.dx, nx_r);
    by     = pchsn_pkg::wrap_step(y_r, off.dy, ny_r);
    bz     = pchsn_pkg::wrap_step(z_r, off.dz, nz_r);
  end

  assign push      = (state_r == F_GEN);
  assign last_push = push && push_ready && (slot_r == pchsn_pkg::LAST_SLOT);
  assign busy      = (state_r == F_GEN) && !last_push;

  assign push_data.nb   = pchsn_pkg::NB_W'(bx) + pchsn_pkg::NB_W'(by) * pchsn_pkg::NB_W'(nx_r)
                        + pchsn_pkg::NB_W'(bz) * pchsn_pkg::NB_W'(nxny_r);
  assign push_data.cell_idx = pchsn_pkg::NB_W'(x_r)
                            + pchsn_pkg::NB_W'(y_r) * pchsn_pkg::NB_W'(nx_r)
                            + pchsn_pkg::NB_W'(z_r) * pchsn_pkg::NB_W'(nxny_r);
  assign push_data.slot = slot_r;
  assign push_data.last = (slot_r == pchsn_pkg::LAST_SLOT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      slot_r  <= '0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (accept) begin
            state_r <= F_GEN;
            slot_r  <= '0;
          end
        end
        F_GEN: begin
          if (push_ready) begin
            if (slot_r == pchsn_pkg::LAST_SLOT) begin
              state_r <= accept ? F_GEN : F_IDLE;
              slot_r  <= '0;
            end else begin
              slot_r <= slot_r + 4'd1;
            end
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
    if (accept) begin
      nx_r   <= nx_nxt;
      ny_r   <= ny_nxt;
      nz_r   <= nz_nxt;
      nxny_r <= pchsn_pkg::AREA_W'(nx_nxt) * pchsn_pkg::AREA_W'(ny_nxt);
      x_r    <= pchsn_pkg::clamp_coord(cell_x, nx_nxt);
      y_r    <= pchsn_pkg::clamp_coord(cell_y, ny_nxt);
      z_r    <= pchsn_pkg::clamp_coord(cell_z, nz_nxt);
    end
  end

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == F_GEN) |-> (slot_r <= pchsn_pkg::LAST_SLOT))
    else $error("front slot out of range");

  a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && state_r == F_GEN) |-> last_push)
    else $error("cell accepted while neighbors remain");

endmodule

### rtl/pchsn_queue.sv
// pchsn_queue: short FIFO of neighbor requests between front and back.
// Depends on pchsn_pkg.
module pchsn_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                push_ready,
  input  pchsn_pkg::nbr_req_t push_data,
  output logic                pop_valid,
  input  logic                pop,
  output pchsn_pkg::nbr_req_t pop_data
);

  pchsn_pkg::nbr_req_t              mem_r [pchsn_pkg::QDEPTH];
  logic [pchsn_pkg::QPTR_W-1:0]     wptr_r, rptr_r;
  logic [pchsn_pkg::QPTR_W:0]       count_r;
  logic                             do_push, do_pop;

  assign push_ready = (count_r != (pchsn_pkg::QPTR_W+1)'(pchsn_pkg::QDEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rptr_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) wptr_r <= wptr_r + 1'b1;
      if (do_pop)  rptr_r <= rptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
    if (do_push) mem_r[wptr_r] <= push_data;
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (pchsn_pkg::QPTR_W+1)'(pchsn_pkg::QDEPTH))
    else $error("queue count overflow");

endmodule

### rtl/pchsn_back.sv
// pchsn_back: reverse-counter read-modify-write, address math and result register.
// Depends on pchsn_pkg; drains pchsn_queue; owns the counter memory and its clearing pass.
module pchsn_back #(
  parameter int unsigned MAX_CELLS = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pchsn_pkg::cfg_t               cfg,
  input  logic                          req_valid,
  output logic                          req_pop,
  input  pchsn_pkg::nbr_req_t           req,
  output pchsn_pkg::back_stat_t         stat,
  output logic                          out_strobe,
  output logic [pchsn_pkg::IDX_W-1:0]   out_neighbor_index,
  output logic [pchsn_pkg::SLOT_W-1:0]  out_slot,
  output logic [pchsn_pkg::CNT_W-1:0]   out_reverse_slot,
  output logic [pchsn_pkg::ADDR_W-1:0]  out_forward_address,
  output logic [pchsn_pkg::ADDR_W-1:0]  out_reverse_address,
  output logic                          out_last
);

  localparam int unsigned AW = ($clog2(MAX_CELLS) > 0) ? $clog2(MAX_CELLS) : 1;
  localparam logic [AW-1:0] CLR_LAST = AW'(MAX_CELLS - 1);

  logic [pchsn_pkg::CNT_W-1:0] cnt_mem [MAX_CELLS];

  logic                          clr_active_r;
  logic [AW-1:0]                 clr_addr_r;

  logic [pchsn_pkg::CNT_W-1:0]   rdata_r;
  logic                          b_vld_r, b_inr_r, b_last_r;
  logic [pchsn_pkg::NB_W-1:0]    b_nb_r;
  logic [AW-1:0]                 b_addr_r;
  logic [pchsn_pkg::SLOT_W-1:0]  b_slot_r;
  logic [pchsn_pkg::ADDR_W-1:0]  b_nbs_r, b_cs_r;

  logic                          lw_vld_r;
  logic [AW-1:0]                 lw_addr_r;
  logic [pchsn_pkg::CNT_W-1:0]   lw_data_r;

  logic                          out_strobe_r, out_last_r;
  logic [pchsn_pkg::IDX_W-1:0]   out_idx_r;
  logic [pchsn_pkg::SLOT_W-1:0]  out_slot_r;
  logic [pchsn_pkg::CNT_W-1:0]   out_rslot_r;
  logic [pchsn_pkg::ADDR_W-1:0]  out_fwd_r, out_rev_r;

  logic                          a_inr;
  logic [AW-1:0]                 a_addr;
  logic [pchsn_pkg::CNT_W-1:0]   rslot, cnt_nxt;
  logic                          upd_en, wr_en;
  logic [AW-1:0]                 wr_addr;
  logic [pchsn_pkg::CNT_W-1:0]   wr_data;

  assign req_pop       = req_valid && !clr_active_r;
  assign stat.clearing = clr_active_r;
  assign a_inr         = (32'(req.nb) < MAX_CELLS);
  assign a_addr        = req.nb[AW-1:0];

  always_comb begin
    if (!b_inr_r) rslot = '0;
    else if (lw_vld_r && (lw_addr_r == b_addr_r)) rslot = lw_data_r;
    else rslot = rdata_r;
    cnt_nxt = (rslot == pchsn_pkg::CNT_MAX) ? rslot : rslot + 6'd1;
    upd_en  = b_vld_r && b_inr_r;
    wr_en   = clr_active_r || upd_en;
    wr_addr = clr_active_r ? clr_addr_r : b_addr_r;
    wr_data = clr_active_r ? '0 : cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) cnt_mem[wr_addr] <= wr_data;
    rdata_r <= cnt_mem[a_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      b_vld_r      <= 1'b0;
      lw_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      if (clr_active_r) begin
        if (clr_addr_r == CLR_LAST) clr_active_r <= 1'b0;
        else clr_addr_r <= clr_addr_r + 1'b1;
      end
      b_vld_r      <= req_pop;
      lw_vld_r     <= upd_en;
      out_strobe_r <= b_vld_r;
    end
    b_inr_r   <= a_inr;
    b_addr_r  <= a_addr;
    b_nb_r    <= req.nb;
    b_slot_r  <= req.slot;
    b_last_r  <= req.last;
    b_nbs_r   <= pchsn_pkg::ADDR_W'(req.nb * pchsn_pkg::NB_W'(cfg.list_stride));
    b_cs_r    <= pchsn_pkg::ADDR_W'(req.cell_idx * pchsn_pkg::NB_W'(cfg.list_stride));
    lw_addr_r <= b_addr_r;
    lw_data_r <= cnt_nxt;
    out_idx_r   <= b_nb_r[pchsn_pkg::IDX_W-1:0];
    out_slot_r  <= b_slot_r;
    out_rslot_r <= rslot;
    out_fwd_r   <= b_cs_r + pchsn_pkg::ADDR_W'(b_slot_r);
    out_rev_r   <= b_nbs_r + pchsn_pkg::ADDR_W'(rslot);
    out_last_r  <= b_last_r;
  end

  assign out_strobe          = out_strobe_r;
  assign out_neighbor_index  = out_idx_r;
  assign out_slot            = out_slot_r;
  assign out_reverse_slot    = out_rslot_r;
  assign out_forward_address = out_fwd_r;
  assign out_reverse_address = out_rev_r;
  assign out_last            = out_last_r;

  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !b_vld_r)
    else $error("request in flight during counter clear");

  a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (b_vld_r && !b_inr_r) |=> (out_strobe && out_reverse_slot == '0))
    else $error("out-of-store neighbor got a nonzero reverse slot");

  a_last_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_last) |-> (out_slot == pchsn_pkg::LAST_SLOT))
    else $error("last flag off the final slot");

endmodule

### rtl/periodic_cell_half_shell_neighbors_top.sv
// periodic_cell_half_shell_neighbors_top: periodic-grid half-shell neighbor generator.
// Depends on pchsn_pkg, pchsn_front, pchsn_queue, pchsn_back.
//
//   channel   handshake              payload
//   input     start / busy           in_cell_x, in_cell_y, in_cell_z
//   result    out_strobe (no stall)  out_neighbor_index, out_slot, out_reverse_slot,
//                                    out_forward_address, out_reverse_address, out_last
//   config    cfg_valid / cfg_ready  cfg_index, cfg_wdata
//
// Each cell produces 13 beats, one per cycle; a new cell is accepted as the front pushes
// the previous cell's last beat, set by the front's slot sequencer and the one counter
// read-modify-write per cycle. The first beat is registered in the queue, then in the
// back's request stage and output register. After reset, busy stays high while the
// counter memory is cleared. Results cannot be stalled; config is always ready.
module periodic_cell_half_shell_neighbors_top #(
  parameter int unsigned MAX_CELLS = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [pchsn_pkg::COORD_W-1:0]   in_cell_x,
  input  logic [pchsn_pkg::COORD_W-1:0]   in_cell_y,
  input  logic [pchsn_pkg::COORD_W-1:0]   in_cell_z,
  output logic                            out_strobe,
  output logic [pchsn_pkg::IDX_W-1:0]     out_neighbor_index,
  output logic [pchsn_pkg::SLOT_W-1:0]    out_slot,
  output logic [pchsn_pkg::CNT_W-1:0]     out_reverse_slot,
  output logic [pchsn_pkg::ADDR_W-1:0]    out_forward_address,
  output logic [pchsn_pkg::ADDR_W-1:0]    out_reverse_address,
  output logic                            out_last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pchsn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pchsn_pkg::SIZE_W-1:0]    cfg_wdata
);

  pchsn_pkg::cfg_t        cfg_r;
  pchsn_pkg::back_stat_t  back_stat;
  pchsn_pkg::nbr_req_t    q_in, q_out;
  logic                   front_busy, accept;
  logic                   q_push, q_push_ready, q_pop_valid, q_pop;

  assign cfg_ready = 1'b1;
  assign busy      = front_busy || back_stat.clearing;
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.size_x      <= pchsn_pkg::SIZE_X_RST;
      cfg_r.size_y      <= pchsn_pkg::SIZE_Y_RST;
      cfg_r.size_z      <= pchsn_pkg::SIZE_Z_RST;
      cfg_r.list_stride <= pchsn_pkg::STRIDE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pchsn_pkg::REG_SIZE_X:      cfg_r.size_x      <= cfg_wdata;
        pchsn_pkg::REG_SIZE_Y:      cfg_r.size_y      <= cfg_wdata;
        pchsn_pkg::REG_SIZE_Z:      cfg_r.size_z      <= cfg_wdata;
        pchsn_pkg::REG_LIST_STRIDE: cfg_r.list_stride <= cfg_wdata;
        default: ;
      endcase
    end
  end

  pchsn_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .accept     (accept),
    .cell_x     (in_cell_x),
    .cell_y     (in_cell_y),
    .cell_z     (in_cell_z),
    .busy       (front_busy),
    .push       (q_push),
    .push_ready (q_push_ready),
    .push_data  (q_in)
  );

  pchsn_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_ready (q_push_ready),
    .push_data  (q_in),
    .pop_valid  (q_pop_valid),
    .pop        (q_pop),
    .pop_data   (q_out)
  );

  pchsn_back #(
    .MAX_CELLS (MAX_CELLS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .req_valid           (q_pop_valid),
    .req_pop             (q_pop),
    .req                 (q_out),
    .stat                (back_stat),
    .out_strobe          (out_strobe),
    .out_neighbor_index  (out_neighbor_index),
    .out_slot            (out_slot),
    .out_reverse_slot    (out_reverse_slot),
    .out_forward_address (out_forward_address),
    .out_reverse_address (out_reverse_address),
    .out_last            (out_last)
  );

endmodule
